// File: rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg - shared types and constants of the sorted key table
// Transaction structs, entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DefCapacity = 128;
  // cells combined by one registered reduction group
  localparam int GroupSize   = 16;

  localparam int KeyW    = 31;
  localparam int PriceW  = 24;
  localparam int HandleW = 32;
  localparam int TotalW  = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic [KeyW-1:0]    key;
    logic [PriceW-1:0]  price_cents;
    logic [HandleW-1:0] title_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [PriceW-1:0]  found_price_cents;
    logic [HandleW-1:0] found_handle;
    logic [TotalW-1:0]  entry_total;
  } out_item_t;

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [PriceW-1:0]  price;
    logic [HandleW-1:0] handle;
  } entry_t;

  // broadcast command from the sequencer to every cell
  typedef struct packed {
    logic capture;    // latch compare flags against the operand key
    logic do_insert;  // shift up and drop the new entry in
    logic do_remove;  // shift down over the matched entry
  } cell_cmd_t;

endpackage

// File: rtl/core/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell - one slot of the sorted key table
// Holds one entry, compares it with the operand key and shifts with neighbors.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  skt_pkg::cell_cmd_t cmd,
  input  skt_pkg::entry_t   new_entry,
  input  logic              occ,        // slot index below entry count
  input  logic              at_end,     // slot index equals entry count
  input  logic              prev_gt,
  input  skt_pkg::entry_t   prev_entry,
  input  logic              next_occ,
  input  skt_pkg::entry_t   next_entry,
  output skt_pkg::entry_t   entry,
  output logic              gt,
  output logic              eq
);
  import skt_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   gt_r, gt_nxt;
  logic   eq_r, eq_nxt;

  always_comb begin
    gt_nxt = gt_r;
    eq_nxt = eq_r;
    if (cmd.capture) begin
      gt_nxt = occ && (entry_r.key > new_entry.key);
      eq_nxt = occ && (entry_r.key == new_entry.key);
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.do_insert) begin
      if ((occ || at_end) && prev_gt) begin
        entry_nxt = prev_entry;
      end else if (at_end || (occ && gt_r)) begin
        entry_nxt = new_entry;
      end
    end else if (cmd.do_remove) begin
      // matched slot and every larger key pull from the right
      if ((eq_r || gt_r) && next_occ) begin
        entry_nxt = next_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      gt_r <= gt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign gt    = gt_r;
  assign eq    = eq_r;

endmodule

// File: rtl/core/skt_group.sv
// ----------------------------------------------------------------------------
// skt_group - registered match reduction over one group of cells
// ORs the match flags and selects the matched price and handle.
// ----------------------------------------------------------------------------
module skt_group (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [skt_pkg::GroupSize-1:0]        eq,
  input  skt_pkg::entry_t [skt_pkg::GroupSize-1:0] ent,
  output logic                                 hit,
  output logic [skt_pkg::PriceW-1:0]           price,
  output logic [skt_pkg::HandleW-1:0]          handle
);
  import skt_pkg::*;

  logic               hit_r, hit_nxt;
  logic [PriceW-1:0]  price_r, price_nxt;
  logic [HandleW-1:0] handle_r, handle_nxt;

  // keys are unique, so at most one flag is set: plain and-or select
  always_comb begin
    hit_nxt    = |eq;
    price_nxt  = '0;
    handle_nxt = '0;
    for (int k = 0; k < GroupSize; k++) begin
      price_nxt  = price_nxt  | (ent[k].price  & {PriceW{eq[k]}});
      handle_nxt = handle_nxt | (ent[k].handle & {HandleW{eq[k]}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r  <= price_nxt;
    handle_r <= handle_nxt;
  end

  assign hit    = hit_r;
  assign price  = price_r;
  assign handle = handle_r;

endmodule

// File: rtl/core/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table - sorted table with insert, remove and search
// A chain of CAPACITY cells keeps entries in ascending key order.
// ----------------------------------------------------------------------------
//
//  channel  | ports                    | payload
//  ---------+--------------------------+-----------------------------------
//  input    | in_valid in_stall in_data | op, key, price_cents, title_handle
//  result   | out_valid out_stall out_data | status, price, handle, total
//
//  Each transaction runs through these steps from acceptance to the next
//  acceptance: accept, compare in every cell, group reduction, final
//  reduction and status, then a shift in the cell chain. The reduction
//  runs in two registered levels over GroupSize-cell groups.
//  Reset (rst_n low, synchronous) clears the entry count and the sequencer;
//  cell contents are left as they are, since slots at or above the count
//  are never read. A stalled result holds the sequencer in the status
//  cycle; the result register frees the chain as soon as it is loaded.
//
module sorted_key_table #(
  parameter int CAPACITY = skt_pkg::DefCapacity
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  skt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output skt_pkg::out_item_t out_data
);
  import skt_pkg::*;

  localparam int CntW      = $clog2(CAPACITY + 1);
  localparam int NumGroups = (CAPACITY + GroupSize - 1) / GroupSize;
  localparam int NumPad    = NumGroups * GroupSize;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_RED,
    S_APPLY
  } state_t;

  state_t    state_r;
  in_item_t  op_r;           // operand of the transaction at work
  logic [CntW-1:0] count_r;
  logic      do_ins_r, do_rem_r;
  logic      out_valid_r;
  out_item_t out_r;

  cell_cmd_t cmd;
  entry_t    new_entry;

  // cell chain wiring
  entry_t          cell_entry [CAPACITY];
  logic            cell_gt    [CAPACITY];
  logic            cell_eq    [CAPACITY];
  logic            cell_occ   [CAPACITY];
  logic            cell_end   [CAPACITY];
  logic            nb_prev_gt [CAPACITY];
  entry_t          nb_prev    [CAPACITY];
  logic            nb_next_occ[CAPACITY];
  entry_t          nb_next    [CAPACITY];

  logic [NumPad-1:0]            pad_eq;
  entry_t [NumPad-1:0]          pad_ent;
  logic [NumGroups-1:0]         grp_hit;
  logic [PriceW-1:0]            grp_price  [NumGroups];
  logic [HandleW-1:0]           grp_handle [NumGroups];

  assign new_entry = '{key: op_r.key, price: op_r.price_cents, handle: op_r.title_handle};

  assign cmd.capture   = (state_r == S_CMP);
  assign cmd.do_insert = (state_r == S_APPLY) && do_ins_r;
  assign cmd.do_remove = (state_r == S_APPLY) && do_rem_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i] = (CntW'(i) < count_r);
    assign cell_end[i] = (CntW'(i) == count_r);

    if (i == 0) begin : g_first
      assign nb_prev_gt[i] = 1'b0;
      assign nb_prev[i]    = '0;
    end else begin : g_mid
      assign nb_prev_gt[i] = cell_gt[i-1];
      assign nb_prev[i]    = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign nb_next_occ[i] = 1'b0;
      assign nb_next[i]     = '0;
    end else begin : g_inner
      assign nb_next_occ[i] = cell_occ[i+1];
      assign nb_next[i]     = cell_entry[i+1];
    end

    skt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_entry  (new_entry),
      .occ        (cell_occ[i]),
      .at_end     (cell_end[i]),
      .prev_gt    (nb_prev_gt[i]),
      .prev_entry (nb_prev[i]),
      .next_occ   (nb_next_occ[i]),
      .next_entry (nb_next[i]),
      .entry      (cell_entry[i]),
      .gt         (cell_gt[i]),
      .eq         (cell_eq[i])
    );
  end

  // pad the chain up to whole groups
  for (genvar j = 0; j < NumPad; j++) begin : g_pad
    if (j < CAPACITY) begin : g_real
      assign pad_eq[j]  = cell_eq[j];
      assign pad_ent[j] = cell_entry[j];
    end else begin : g_fill
      assign pad_eq[j]  = 1'b0;
      assign pad_ent[j] = '0;
    end
  end

  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    skt_group u_group (
      .clk    (clk),
      .rst_n  (rst_n),
      .eq     (pad_eq[g*GroupSize +: GroupSize]),
      .ent    (pad_ent[g*GroupSize +: GroupSize]),
      .hit    (grp_hit[g]),
      .price  (grp_price[g]),
      .handle (grp_handle[g])
    );
  end

  // final reduction and status decision, used in the status cycle
  logic               hit;
  logic [PriceW-1:0]  sel_price;
  logic [HandleW-1:0] sel_handle;
  logic               tbl_full, tbl_empty;
  logic [2:0]         status;
  logic               ins_ok, rem_ok, srch_ok;
  logic [CntW-1:0]    count_after;

  always_comb begin
    hit        = |grp_hit;
    sel_price  = '0;
    sel_handle = '0;
    for (int g = 0; g < NumGroups; g++) begin
      sel_price  = sel_price  | (grp_price[g]  & {PriceW{grp_hit[g]}});
      sel_handle = sel_handle | (grp_handle[g] & {HandleW{grp_hit[g]}});
    end
  end

  assign tbl_full  = (count_r == CntW'(CAPACITY));
  assign tbl_empty = (count_r == '0);

  always_comb begin
    status  = ST_OK;
    ins_ok  = 1'b0;
    rem_ok  = 1'b0;
    srch_ok = 1'b0;
    unique case (op_r.op)
      OP_INSERT: begin
        if (tbl_full) begin
          status = ST_FULL;
        end else if (hit) begin
          status = ST_DUPLICATE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (tbl_empty) begin
          status = ST_EMPTY;
        end else if (!hit) begin
          status = ST_NOTFOUND;
        end else begin
          rem_ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        if (tbl_empty) begin
          status = ST_EMPTY;
        end else if (!hit) begin
          status = ST_NOTFOUND;
        end else begin
          srch_ok = 1'b1;
        end
      end
      default: begin
        // unused op code: no change, plain ok
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_after = count_r;
    if (ins_ok) begin
      count_after = count_r + CntW'(1);
    end else if (rem_ok) begin
      count_after = count_r - CntW'(1);
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      do_ins_r    <= 1'b0;
      do_rem_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result wins over the drain of the old one
      if ((state_r == S_RED) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_GRP;
        end
        S_GRP: begin
          state_r <= S_RED;
        end
        S_RED: begin
          if (out_free) begin
            do_ins_r    <= ins_ok;
            do_rem_r    <= rem_ok;
            state_r     <= S_APPLY;
          end
        end
        S_APPLY: begin
          // cells shift on the old count, then the count moves
          if (do_ins_r) begin
            count_r <= count_r + CntW'(1);
          end else if (do_rem_r) begin
            count_r <= count_r - CntW'(1);
          end
          do_ins_r <= 1'b0;
          do_rem_r <= 1'b0;
          state_r  <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      op_r <= in_data;
    end
    if ((state_r == S_RED) && out_free) begin
      out_r.status            <= status;
      out_r.found_price_cents <= srch_ok ? sel_price  : '0;
      out_r.found_handle      <= srch_ok ? sel_handle : '0;
      out_r.entry_total       <= TotalW'(count_after);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_moves_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(state_r == S_APPLY))
    else $error("entry count changed outside the shift cycle");

  a_result_from_status: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RED))
    else $error("result raised outside the status cycle");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_ins_r && do_rem_r))
    else $error("insert and remove shift at once");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the sorted key table
// Runs inserts, removes and searches through the valid/stall channels and
// tracks a shadow copy of the table to check every result. Tests cover the
// empty table, key and field extremes, duplicates, a full table and random
// traffic. Both channels idle at random in several phases.
// ----------------------------------------------------------------------------
module tb;
  import skt_pkg::*;

  localparam int CAP = 128;
  localparam int QUIET_LIMIT = 4000;   // cycles with no transaction on either side
  localparam int TAIL_CYCLES = 20;
  // op code 3 has no meaning; the table must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [KeyW-1:0] KEY_TOP = '1;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  sorted_key_table #(.CAPACITY(CAP)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Shadow table: sorted entries below 'held' are live.
  logic [KeyW-1:0]    tbl_key    [CAP];
  logic [PriceW-1:0]  tbl_price  [CAP];
  logic [HandleW-1:0] tbl_handle [CAP];
  int                 held = 0;

  out_item_t table_replies[$];   // replies owed by the block, oldest first
  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one operation to the shadow table and returns the reply it owes.
  function automatic out_item_t table_apply(input in_item_t it);
    out_item_t r;
    int slot;
    int i;
    r = '0;
    r.status = ST_OK;
    slot = held;
    for (i = 0; i < held; i++) begin
      if (tbl_key[i] == it.key && slot == held) slot = i;
    end
    case (it.op)
      OP_INSERT: begin
        // full wins over duplicate
        if (held >= CAP) r.status = ST_FULL;
        else if (slot < held) r.status = ST_DUPLICATE;
        else begin
          i = held;
          while (i > 0 && tbl_key[i-1] > it.key) begin
            tbl_key[i]    = tbl_key[i-1];
            tbl_price[i]  = tbl_price[i-1];
            tbl_handle[i] = tbl_handle[i-1];
            i--;
          end
          tbl_key[i]    = it.key;
          tbl_price[i]  = it.price_cents;
          tbl_handle[i] = it.title_handle;
          held++;
        end
      end
      OP_REMOVE: begin
        if (held == 0) r.status = ST_EMPTY;
        else if (slot >= held) r.status = ST_NOTFOUND;
        else begin
          for (i = slot; i + 1 < held; i++) begin
            tbl_key[i]    = tbl_key[i+1];
            tbl_price[i]  = tbl_price[i+1];
            tbl_handle[i] = tbl_handle[i+1];
          end
          held--;
        end
      end
      OP_SEARCH: begin
        if (held == 0) r.status = ST_EMPTY;
        else if (slot >= held) r.status = ST_NOTFOUND;
        else begin
          r.found_price_cents = tbl_price[slot];
          r.found_handle      = tbl_handle[slot];
        end
      end
      default: ;   // unused op: nothing changes
    endcase
    r.entry_total = held[TotalW-1:0];
    return r;
  endfunction

  function automatic in_item_t mk(input logic [1:0] op, input logic [KeyW-1:0] key,
                                  input logic [PriceW-1:0] price,
                                  input logic [HandleW-1:0] handle);
    in_item_t it;
    it.op           = op;
    it.key          = key;
    it.price_cents  = price;
    it.title_handle = handle;
    return it;
  endfunction

  // Key source: held keys hit_pct of the time, then low keys, keys at the
  // top of the range, and anything else.
  function automatic logic [KeyW-1:0] pick_key(input int hit_pct);
    int r;
    logic [KeyW-1:0] k;
    r = $urandom_range(0, 99);
    if (held > 0 && r < hit_pct) k = tbl_key[$urandom_range(0, held - 1)];
    else if (r < hit_pct + 10) k = $urandom_range(0, 15);
    else if (r < hit_pct + 15) k = KEY_TOP - $urandom_range(0, 3);
    else k = $urandom;
    return k;
  endfunction

  function automatic logic [PriceW-1:0] rand_price();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  // Sends one transaction; valid stays high afterwards so back-to-back items
  // need no gap. The prediction is made at the accepting edge.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    table_replies.push_back(table_apply(it));
  endtask

  task automatic set_idling(input int sender, input int receiver);
    send_idle_pct  = sender;
    recv_stall_pct = receiver;
  endtask

  // Result checker and receiver-side stall generator.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (table_replies.size() == 0) begin
        note_error($sformatf("result with none pending: %p", out_data));
      end else begin
        want = table_replies.pop_front();
        if (out_data.status !== want.status)
          note_error($sformatf("status: exp %0d got %0d", want.status, out_data.status));
        if (out_data.found_price_cents !== want.found_price_cents)
          note_error($sformatf("price: exp %0h got %0h", want.found_price_cents,
                               out_data.found_price_cents));
        if (out_data.found_handle !== want.found_handle)
          note_error($sformatf("handle: exp %0h got %0h", want.found_handle,
                               out_data.found_handle));
        if (out_data.entry_total !== want.entry_total)
          note_error($sformatf("total: exp %0d got %0d", want.entry_total,
                               out_data.entry_total));
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: no transaction on either channel for too long means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Empty table, field extremes, ordering in the middle/ends, duplicates,
  // misses and the unused op.
  task automatic test_basic_ops();
    send_item(mk(OP_SEARCH, 31'd5, '0, '0));            // empty search
    send_item(mk(OP_REMOVE, KEY_TOP, '1, '1));          // empty remove
    send_item(mk(OP_UNUSED, '0, '0, '0));               // ignored on empty
    send_item(mk(OP_INSERT, '0, '0, '0));
    send_item(mk(OP_INSERT, KEY_TOP, '1, '1));
    send_item(mk(OP_INSERT, 31'd1000, 24'd123, 32'hA5A5_A5A5));
    send_item(mk(OP_INSERT, 31'd500, 24'h5A5A5A, 32'h5A5A_5A5A));  // lands mid-table
    send_item(mk(OP_INSERT, 31'd1000, 24'd7, 32'd7));   // duplicate
    send_item(mk(OP_SEARCH, '0, '1, '1));
    send_item(mk(OP_SEARCH, KEY_TOP, '0, '0));
    send_item(mk(OP_SEARCH, 31'd500, '0, '0));
    send_item(mk(OP_SEARCH, 31'd999, '0, '0));          // miss
    send_item(mk(OP_UNUSED, KEY_TOP, '1, '1));          // ignored, fields set
    send_item(mk(OP_REMOVE, 31'd999, '0, '0));          // miss
    send_item(mk(OP_REMOVE, 31'd500, '0, '0));          // middle
    send_item(mk(OP_REMOVE, '0, '0, '0));               // first
    send_item(mk(OP_REMOVE, KEY_TOP, '0, '0));          // last
    send_item(mk(OP_SEARCH, 31'd1000, '0, '0));
    send_item(mk(OP_REMOVE, 31'd1000, '0, '0));
    send_item(mk(OP_SEARCH, 31'd1000, '0, '0));         // empty again
    send_item(mk(OP_REMOVE, 31'd1000, '0, '0));
  endtask

  // Mixed traffic; inserts outnumber removes so the table drifts toward full.
  task automatic test_random_mix(input int n_items);
    int r;
    logic [1:0] op;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_INSERT;
      else if (r < 72) op = OP_REMOVE;
      else if (r < 95) op = OP_SEARCH;
      else op = OP_UNUSED;
      send_item(mk(op, pick_key(55), rand_price(), $urandom));
    end
  endtask

  // Fill to capacity, knock on a full table (fresh and held keys), look up
  // entries, then drain to empty.
  task automatic test_full_table();
    while (held < CAP) send_item(mk(OP_INSERT, pick_key(10), rand_price(), $urandom));
    repeat (4) send_item(mk(OP_INSERT, pick_key(0), rand_price(), $urandom));
    repeat (4) send_item(mk(OP_INSERT, pick_key(100), rand_price(), $urandom));
    repeat (20) send_item(mk(OP_SEARCH, pick_key(80), rand_price(), $urandom));
    while (held > 0) begin
      if ($urandom_range(0, 9) == 0)
        send_item(mk(OP_REMOVE, pick_key(0), rand_price(), $urandom));
      else
        send_item(mk(OP_REMOVE, tbl_key[$urandom_range(0, held - 1)], rand_price(),
                     $urandom));
    end
    send_item(mk(OP_SEARCH, pick_key(0), rand_price(), $urandom));
    send_item(mk(OP_REMOVE, pick_key(0), rand_price(), $urandom));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_basic_ops();
    test_random_mix(360);
    set_idling(63, 0);
    test_random_mix(360);
    set_idling(0, 63);
    test_random_mix(360);
    set_idling(18, 18);
    test_random_mix(360);
    test_full_table();
    set_idling(0, 0);
    test_full_table();

    // drain: every reply in, then a short tail for stray results
    in_valid <= 1'b0;
    while (table_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/skt_group.sv
rtl/core/sorted_key_table.sv
sim/tb.sv
